>>> hdl/tcgw_pkg.sv
// ----------------------------------------------------------------------------
// tcgw_pkg: shared types and constants of the text console glyph writer
// request codes, queue operation codes and the queue entry layout
// ----------------------------------------------------------------------------
package tcgw_pkg;

    localparam int REQ_W     = 2;
    localparam int CODE_W    = 8;
    localparam int FIDX_W    = 11;
    localparam int PIXEL_W   = 8;
    localparam int FB_ADDR_W = 14;
    // glyph store index, wide enough for the largest store (256 glyphs x 16 rows)
    localparam int GIDX_W    = 12;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_FONT = 2'd0,
        REQ_PUT_CHAR  = 2'd1,
        REQ_NEW_LINE  = 2'd2,
        REQ_CLEAR     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PUT   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic                 pre_clear;
        logic [FB_ADDR_W-1:0] addr;
        logic [GIDX_W-1:0]    idx;
        logic [PIXEL_W-1:0]   data;
    } entry_t;

endpackage

>>> hdl/tcgw_front.sv
// ----------------------------------------------------------------------------
// tcgw_front: request intake and cursor tracking
// classifies each request beat, moves the cursor and queues work for the back
// ----------------------------------------------------------------------------
module tcgw_front #(
    parameter int COLUMNS     = 40,
    parameter int ROWS        = 30,
    parameter int GLYPH_ROWS  = 8,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [tcgw_pkg::REQ_W-1:0]     req_type,
    input  logic [tcgw_pkg::CODE_W-1:0]    char_code,
    input  logic [tcgw_pkg::FIDX_W-1:0]    font_index,
    input  logic [tcgw_pkg::PIXEL_W-1:0]   font_data,
    input  logic                           q_full,
    output logic                           enq_valid,
    output tcgw_pkg::entry_t               enq_entry
);
    import tcgw_pkg::*;

    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int LINE_STEP   = COLUMNS * GLYPH_ROWS;
    localparam int COL_W       = $clog2(COLUMNS + 1);
    localparam int ROW_W       = $clog2(ROWS);

    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [FB_ADDR_W-1:0] base_reg, base_next;

    logic                 accept;
    logic                 wrap_row;
    logic [ROW_W-1:0]     row_inc;
    logic [FB_ADDR_W-1:0] base_inc;
    logic [CODE_W-1:0]    code_w;
    logic                 enq_want;

    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;
    assign enq_valid = accept && enq_want;

    assign wrap_row = (row_reg == ROW_W'(ROWS - 1));
    assign row_inc  = wrap_row ? '0 : row_reg + ROW_W'(1);
    assign base_inc = wrap_row ? '0 : base_reg + FB_ADDR_W'(LINE_STEP);
    // codes past the glyph count fold back (code is below twice the count)
    assign code_w   = (32'(char_code) >= GLYPH_COUNT) ?
                      CODE_W'(32'(char_code) - GLYPH_COUNT) : char_code;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        base_next = base_reg;
        enq_want  = 1'b0;
        enq_entry = '{op: OP_CLEAR, pre_clear: 1'b0, addr: '0, idx: '0, data: '0};
        case (req_t'(req_type))
            REQ_LOAD_FONT:
            begin
                enq_want       = (32'(font_index) < STORE_DEPTH);
                enq_entry.op   = OP_LOAD;
                enq_entry.idx  = GIDX_W'(font_index);
                enq_entry.data = font_data;
            end
            REQ_PUT_CHAR:
            begin
                enq_want      = 1'b1;
                enq_entry.op  = OP_PUT;
                enq_entry.idx = GIDX_W'(32'(code_w) * GLYPH_ROWS);
                if (col_reg == COL_W'(COLUMNS))
                begin
                    row_next            = row_inc;
                    base_next           = base_inc;
                    col_next            = COL_W'(1);
                    enq_entry.pre_clear = wrap_row;
                    enq_entry.addr      = base_inc;
                end
                else
                begin
                    col_next       = col_reg + COL_W'(1);
                    enq_entry.addr = base_reg + FB_ADDR_W'(col_reg);
                end
            end
            REQ_NEW_LINE:
            begin
                row_next  = row_inc;
                base_next = base_inc;
                col_next  = '0;
                enq_want  = wrap_row;
            end
            REQ_CLEAR:
            begin
                row_next  = '0;
                base_next = '0;
                col_next  = '0;
                enq_want  = 1'b1;
            end
            default:
            begin
                enq_want = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            base_reg <= '0;
        end
        else if (accept)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            base_reg <= base_next;
        end
    end

endmodule

>>> hdl/tcgw_fifo.sv
// ----------------------------------------------------------------------------
// tcgw_fifo: work queue between front and back
// small register queue of entries, head shown combinationally
// ----------------------------------------------------------------------------
module tcgw_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tcgw_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output tcgw_pkg::entry_t head_entry
);
    import tcgw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> hdl/tcgw_back.sv
// ----------------------------------------------------------------------------
// tcgw_back: glyph store and write sequencer
// executes queued work, reads glyph rows and drives the result register
// ----------------------------------------------------------------------------
module tcgw_back #(
    parameter int COLUMNS     = 40,
    parameter int GLYPH_ROWS  = 8,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  tcgw_pkg::entry_t                head_entry,
    output logic                            pop,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [tcgw_pkg::FB_ADDR_W-1:0]  fb_addr,
    output logic [tcgw_pkg::PIXEL_W-1:0]    pixel_row,
    output logic                            clear_screen,
    output logic                            last
);
    import tcgw_pkg::*;

    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int BEAT_W      = $clog2(GLYPH_ROWS);

    // glyph store, undefined until loaded
    logic [PIXEL_W-1:0] glyph_mem [STORE_DEPTH];

    // work registers
    logic                 act_reg;
    op_t                  kind_reg;
    logic                 clr_pend_reg;
    logic [BEAT_W-1:0]    beat_reg;
    logic [FB_ADDR_W-1:0] addr_reg;
    logic [IDX_W-1:0]     gidx_reg;
    logic [PIXEL_W-1:0]   data_reg;

    // read stage
    logic                 rd_valid_reg;
    logic [FB_ADDR_W-1:0] rd_addr_reg;
    logic                 rd_clear_reg;
    logic                 rd_last_reg;
    logic [PIXEL_W-1:0]   mem_q_reg;

    // result register
    logic                 res_valid_reg;
    logic [FB_ADDR_W-1:0] fb_addr_reg;
    logic [PIXEL_W-1:0]   pixel_row_reg;
    logic                 clear_reg;
    logic                 last_reg;

    logic out_free, slot_free, step, issue, finishing, beat_last;
    logic iss_clear, iss_last;

    assign out_free  = !res_valid_reg || !res_stall;
    assign slot_free = !rd_valid_reg || out_free;
    assign step      = act_reg && ((kind_reg == OP_LOAD) || slot_free);
    assign issue     = step && (kind_reg != OP_LOAD);
    assign beat_last = (beat_reg == BEAT_W'(GLYPH_ROWS - 1));

    always_comb
    begin
        case (kind_reg)
            OP_LOAD:  finishing = 1'b1;
            OP_PUT:   finishing = !clr_pend_reg && beat_last;
            OP_CLEAR: finishing = 1'b1;
            default:  finishing = 1'b1;
        endcase
    end

    assign iss_clear = (kind_reg == OP_CLEAR) || clr_pend_reg;
    assign iss_last  = (kind_reg == OP_CLEAR) || (!clr_pend_reg && beat_last);
    assign pop       = head_valid && (!act_reg || (step && finishing));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                act_reg <= 1'b1;
            else if (step && finishing)
                act_reg <= 1'b0;

            if (issue)
                rd_valid_reg <= 1'b1;
            else if (out_free)
                rd_valid_reg <= 1'b0;

            if (out_free)
                res_valid_reg <= rd_valid_reg;
        end
    end

    // work payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg     <= head_entry.op;
            clr_pend_reg <= head_entry.pre_clear;
            beat_reg     <= '0;
            addr_reg     <= head_entry.addr;
            gidx_reg     <= IDX_W'(head_entry.idx);
            data_reg     <= head_entry.data;
        end
        else if (issue && (kind_reg == OP_PUT))
        begin
            if (clr_pend_reg)
                clr_pend_reg <= 1'b0;
            else
            begin
                beat_reg <= beat_reg + BEAT_W'(1);
                addr_reg <= addr_reg + FB_ADDR_W'(COLUMNS);
                gidx_reg <= gidx_reg + IDX_W'(1);
            end
        end
    end

    // glyph store port: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (step && (kind_reg == OP_LOAD))
            glyph_mem[gidx_reg] <= data_reg;
        if (issue)
            mem_q_reg <= glyph_mem[gidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_addr_reg  <= iss_clear ? '0 : addr_reg;
            rd_clear_reg <= iss_clear;
            rd_last_reg  <= iss_last;
        end
        if (out_free && rd_valid_reg)
        begin
            fb_addr_reg   <= rd_addr_reg;
            pixel_row_reg <= rd_clear_reg ? '0 : mem_q_reg;
            clear_reg     <= rd_clear_reg;
            last_reg      <= rd_last_reg;
        end
    end

    assign res_valid    = res_valid_reg;
    assign fb_addr      = fb_addr_reg;
    assign pixel_row    = pixel_row_reg;
    assign clear_screen = clear_reg;
    assign last         = last_reg;

endmodule

>>> hdl/text_console_glyph_writer.sv
// ----------------------------------------------------------------------------
// text_console_glyph_writer: character console framebuffer writer
// turns console requests into glyph row writes and clear commands
// ----------------------------------------------------------------------------
// Each request beat loads a font byte, puts a character, starts a new line or
// clears the screen. A character becomes GLYPH_ROWS result beats (one per glyph
// row, at row*COLUMNS*GLYPH_ROWS + glyph_row*COLUMNS + column), preceded by a
// clear beat when it wraps from the bottom line to the top; new line and clear
// give at most one clear beat; a font load gives none. The back end emits one
// result beat per cycle while results are not stalled, bounded by the single
// glyph store port, which a character uses once per glyph row (once more with
// a wrap clear); a plain new line costs the back end nothing. A request waits
// in a queue slot, then in the work, read and result registers. A QUEUE_DEPTH
// entry queue lets requests keep arriving while characters are being drawn.
// Glyphs must be loaded before they are drawn; the store has no reset.
// ----------------------------------------------------------------------------
module text_console_glyph_writer #(
    parameter int COLUMNS     = 40,
    parameter int ROWS        = 30,
    parameter int GLYPH_ROWS  = 8,
    parameter int GLYPH_COUNT = 256,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [tcgw_pkg::REQ_W-1:0]      req_type,
    input  logic [tcgw_pkg::CODE_W-1:0]     char_code,
    input  logic [tcgw_pkg::FIDX_W-1:0]     font_index,
    input  logic [tcgw_pkg::PIXEL_W-1:0]    font_data,
    // result channel
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [tcgw_pkg::FB_ADDR_W-1:0]  fb_addr,
    output logic [tcgw_pkg::PIXEL_W-1:0]    pixel_row,
    output logic                            clear_screen,
    output logic                            last
);
    import tcgw_pkg::*;

    // front to queue
    logic   enq_valid;
    entry_t enq_entry;
    logic   q_full;

    // queue to back
    logic   head_valid;
    entry_t head_entry;
    logic   pop;

    // front tracks the cursor at request rate, ahead of the drawing
    tcgw_front #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .font_index (font_index),
        .font_data  (font_data),
        .q_full     (q_full),
        .enq_valid  (enq_valid),
        .enq_entry  (enq_entry)
    );

    // loads travel through the queue too, keeping store writes in order
    tcgw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (enq_valid),
        .push_entry (enq_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // back owns the glyph store and the result register
    tcgw_back #(
        .COLUMNS     (COLUMNS),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .fb_addr      (fb_addr),
        .pixel_row    (pixel_row),
        .clear_screen (clear_screen),
        .last         (last)
    );

endmodule
